// ===== rtl/core/dvf_pkg.sv =====
// ============================================================================
// dvf_pkg
// Shared types and constants for the distinct value filter.
// ============================================================================
package dvf_pkg;

    localparam int unsigned VALUE_W         = 32;
    localparam int unsigned SLOT_W          = 7;
    localparam int unsigned TABLE_DEPTH_DEF = 128;

    // Search token that walks the cell chain
    typedef struct packed {
        logic               vld;
        logic [VALUE_W-1:0] value;
        logic               hit;     // value found in an earlier cell
        logic               stored;  // value written into a free cell
    } probe_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } dvf_state_t;

endpackage

// ===== rtl/core/dvf_cell.sv =====
// ============================================================================
// dvf_cell
// One table entry of the chain: compares the passing token, stores it when
// the token reaches the first free entry without a hit.
// ============================================================================
module dvf_cell #(
    parameter int unsigned DEPTH    = dvf_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned CELL_IDX = 0
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dvf_pkg::probe_t                   probe_i,
    input  logic [$clog2(DEPTH+1)-1:0]        count_i,
    output dvf_pkg::probe_t                   probe_o
);
    import dvf_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [VALUE_W-1:0] entry_reg;
    probe_t             probe_reg;
    probe_t             probe_next;
    logic               live;
    logic               at_free;
    logic               match;
    logic               wr;

    assign live    = count_i > CNT_W'(CELL_IDX);
    assign at_free = count_i == CNT_W'(CELL_IDX);
    assign match   = probe_i.vld && live && (entry_reg == probe_i.value);
    // Entries past the fill point never match, so the hit flag is final here
    assign wr      = probe_i.vld && at_free && !probe_i.hit;

    always_comb begin
        probe_next        = probe_i;
        probe_next.hit    = probe_i.hit | match;
        probe_next.stored = probe_i.stored | wr;
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            entry_reg <= probe_i.value;
        end
    end

    // Only the valid bit needs a reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg.vld <= 1'b0;
        end else begin
            probe_reg.vld <= probe_next.vld;
        end
        probe_reg.value  <= probe_next.value;
        probe_reg.hit    <= probe_next.hit;
        probe_reg.stored <= probe_next.stored;
    end

    assign probe_o = probe_reg;

endmodule

// ===== rtl/core/dvf_ctrl.sv =====
// ============================================================================
// dvf_ctrl
// Sequencer: launches one token per transaction, keeps the fill count and
// holds the result in the output register.
// ============================================================================
module dvf_ctrl #(
    parameter int unsigned DEPTH = dvf_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [dvf_pkg::VALUE_W-1:0]            s_tdata,
    input  logic                                   s_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [dvf_pkg::VALUE_W+7:0]            m_tdata,
    output logic                                   m_tuser,
    output dvf_pkg::probe_t                        head_o,
    input  dvf_pkg::probe_t                        tail_i,
    output logic [$clog2(DEPTH+1)-1:0]             count_o
);
    import dvf_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned PAD_W = VALUE_W + 8 - VALUE_W - SLOT_W;

    dvf_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               last_reg;
    logic               res_hit_reg;
    logic [VALUE_W-1:0] res_value_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic               res_drop_reg;
    logic               out_vld_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic               out_drop_reg;
    logic               accept;
    logic               tail_seen;
    logic               load_out;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (tail_i.vld) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_hit_reg || !out_vld_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_tready  = 1'b0;
        tail_seen = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready  = 1'b1;
            ST_SCAN: tail_seen = tail_i.vld;
            ST_DONE: load_out  = !res_hit_reg && (!out_vld_reg || m_tready);
            default: s_tready  = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_comb begin
        head_o.vld    = accept;
        head_o.value  = s_tdata;
        head_o.hit    = 1'b0;
        head_o.stored = 1'b0;
    end

    // Fill count changes only once the token has left the chain
    always_comb begin
        count_next = count_reg;
        if (tail_seen) begin
            if (last_reg) begin
                count_next = '0;
            end else if (tail_i.stored) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg <= s_tlast;
        end
        if (tail_seen) begin
            res_hit_reg   <= tail_i.hit;
            res_value_reg <= tail_i.value;
            res_slot_reg  <= tail_i.stored ? SLOT_W'(count_reg) : '0;
            res_drop_reg  <= !tail_i.stored;
        end
        if (load_out) begin
            out_value_reg <= res_value_reg;
            out_slot_reg  <= res_slot_reg;
            out_drop_reg  <= res_drop_reg;
        end
    end

    assign count_o  = count_reg;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {PAD_W'(0), out_slot_reg, out_value_reg};
    assign m_tuser  = out_drop_reg;

endmodule

// ===== rtl/core/distinct_value_filter_top.sv =====
// ============================================================================
// distinct_value_filter_top
// Stream deduplication filter built as a chain of table cells.
// ============================================================================
// Passes on the first occurrence of each 32-bit value within a set and drops
// repeats. Each transaction launches a search token into a chain of
// TABLE_DEPTH cells; the token moves one cell per clock, each cell compares
// it against its stored entry, and the first free cell stores it if no
// earlier cell matched. s_tready stays low after an acceptance at least until
// the token has left the chain and its result is registered, so the filter
// takes no new transaction while one is in flight; the result appears on the
// master side in the same cycle s_tready returns. A new value that finds the
// table full is emitted with m_tuser set (dropped) and slot 0, and is not
// stored. A transaction with s_tlast set clears the table after it is
// handled. Repeats produce no output transaction. The output register lets a
// new transaction be accepted while the previous result still waits for
// m_tready; a fresh result that finds the output register still occupied
// holds s_tready low until the receiver takes the older one.
// ============================================================================
module distinct_value_filter_top #(
    parameter int unsigned TABLE_DEPTH = dvf_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dvf_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] value
    input  logic                          s_tlast,   // last_of_set
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dvf_pkg::VALUE_W+7:0]   m_tdata,   // [31:0] distinct_value,
                                                     // [38:32] slot, [39] zero
    output logic                          m_tuser    // [0] dropped
);
    import dvf_pkg::*;

    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    probe_t           chain [TABLE_DEPTH+1];
    logic [CNT_W-1:0] count;

    dvf_ctrl #(
        .DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .head_o   (chain[0]),
        .tail_i   (chain[TABLE_DEPTH]),
        .count_o  (count)
    );

    // Cell i holds table entry i
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        dvf_cell #(
            .DEPTH    (TABLE_DEPTH),
            .CELL_IDX (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .probe_i (chain[i]),
            .count_i (count),
            .probe_o (chain[i+1])
        );
    end

endmodule

// ===== rtl/core/dvf_checker.sv =====
// ============================================================================
// dvf_checker
// Port-level assertions for the distinct value filter.
// ============================================================================
module dvf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // One transaction in flight: busy right after an acceptance
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted back to back");

    // Dropped values carry slot 0
    a_drop_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[38:32] == 7'd0)
        else $error("dropped result with nonzero slot");

    // Pad bit stays zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[39])
        else $error("pad bit set");

endmodule

bind distinct_value_filter_top dvf_checker u_dvf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
